FILE: rtl/button_debounce_press_hold_repeat_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debouncer
// Shared macros for the concurrent checks that watch the top-level ports.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_REPEAT_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_REPEAT_TOP_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define BDPHR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BDPHR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bdphr_pkg.sv
// ----------------------------------------------------------------------------
// Button debouncer package
// Payload types, register map and reset values of the button debouncer.
// ----------------------------------------------------------------------------
package bdphr_pkg;

    localparam int CFG_TIME_W = 24;
    localparam int PADDR_W    = 4;
    localparam int REPEAT_W   = 8;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE     = 2'd1;
    localparam logic [1:0] REG_HOLD         = 2'd2;
    localparam logic [1:0] REG_MULTI_PRESS  = 2'd3;

    localparam logic                  RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [CFG_TIME_W-1:0] RST_DEBOUNCE     = 24'd50;
    localparam logic [CFG_TIME_W-1:0] RST_HOLD         = 24'd1000;
    localparam logic [CFG_TIME_W-1:0] RST_MULTI_PRESS  = 24'd300;

    typedef struct packed {
        logic pin_level;
        logic take_press;
        logic take_hold;
    } item_t;

    typedef struct packed {
        logic                press_event;
        logic                hold_event;
        logic                pressed_now;
        logic                held_now;
        logic [REPEAT_W-1:0] repeat_count;
    } result_t;

endpackage

FILE: rtl/button_debounce_press_hold_repeat_top.sv
// ----------------------------------------------------------------------------
// Button debouncer with hold and quick-repeat detection
// Debounces one pin sample per transaction and reports press, hold and repeats.
// ----------------------------------------------------------------------------
// One sample transaction is taken per clock cycle; its result appears in the
// output register on the next cycle. The whole update (two saturating timers,
// three threshold compares and the event flags) is combinational, so the
// output register is the only thing that can hold off input: a new sample is
// taken whenever it is empty or being read in that cycle. The user must write
// the configuration registers over the APB port only while idle; not enforced.
module button_debounce_press_hold_repeat_top
    import bdphr_pkg::*;
#(
    parameter int TIME_BITS  = 24,
    parameter int COUNT_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
    localparam int DSP_W = (COUNT_BITS > REPEAT_W) ? COUNT_BITS : REPEAT_W;
    localparam logic [DSP_W-1:0] DSP_MAX = DSP_W'({REPEAT_W{1'b1}});

    // Configuration registers
    logic                  active_level_reg;
    logic [CFG_TIME_W-1:0] debounce_reg;
    logic [CFG_TIME_W-1:0] hold_reg;
    logic [CFG_TIME_W-1:0] multi_press_reg;

    // Button state
    logic                  press_timing_reg, press_timing_next;
    logic [TIME_BITS-1:0]  press_elapsed_reg, press_elapsed_next;
    logic [TIME_BITS-1:0]  release_elapsed_reg, release_elapsed_next;
    logic                  debounced_reg, debounced_next;
    logic                  held_reg, held_next;
    logic                  press_pending_reg, press_pending_next;
    logic                  hold_pending_reg, hold_pending_next;
    logic [COUNT_BITS-1:0] repeat_reg, repeat_next;

    logic                  result_valid_reg;
    result_t               result_reg, result_next;

    logic                  accept;
    logic                  pressed;
    logic [TIME_BITS-1:0]  press_inc;
    logic [TIME_BITS-1:0]  release_inc;
    logic                  past_debounce;
    logic                  past_hold;
    logic                  in_window;
    logic [DSP_W-1:0]      repeat_wide;

    assign pready       = 1'b1;
    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- Configuration port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= RST_ACTIVE_LEVEL;
            debounce_reg     <= RST_DEBOUNCE;
            hold_reg         <= RST_HOLD;
            multi_press_reg  <= RST_MULTI_PRESS;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_ACTIVE_LEVEL: active_level_reg <= pwdata[0];
                REG_DEBOUNCE:     debounce_reg     <= pwdata[CFG_TIME_W-1:0];
                REG_HOLD:         hold_reg         <= pwdata[CFG_TIME_W-1:0];
                REG_MULTI_PRESS:  multi_press_reg  <= pwdata[CFG_TIME_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ACTIVE_LEVEL: prdata = {31'd0, active_level_reg};
            REG_DEBOUNCE:     prdata = {8'd0, debounce_reg};
            REG_HOLD:         prdata = {8'd0, hold_reg};
            REG_MULTI_PRESS:  prdata = {8'd0, multi_press_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- Per-sample update ----------------
    assign pressed     = (item.pin_level == active_level_reg);
    assign release_inc = (&release_elapsed_reg) ? release_elapsed_reg
                                                : release_elapsed_reg + TIME_BITS'(1);
    assign press_inc   = (!press_timing_reg || (&press_elapsed_reg)) ? press_elapsed_reg
                                                                     : press_elapsed_reg + TIME_BITS'(1);

    // Timers and thresholds are compared at a common width so that any
    // TIME_BITS works against the fixed-width registers.
    assign past_debounce = CMP_W'(press_inc) >= CMP_W'(debounce_reg);
    assign past_hold     = CMP_W'(press_inc) >= CMP_W'(hold_reg);
    assign in_window     = CMP_W'(release_inc) < CMP_W'(multi_press_reg);

    always_comb
    begin
        press_pending_next   = press_pending_reg && !item.take_press;
        hold_pending_next    = hold_pending_reg && !item.take_hold;
        release_elapsed_next = release_inc;
        press_elapsed_next   = press_inc;
        press_timing_next    = press_timing_reg;
        debounced_next       = debounced_reg;
        held_next            = held_reg;
        repeat_next          = repeat_reg;

        if (pressed)
        begin
            if (!press_timing_reg)
            begin
                press_timing_next  = 1'b1;
                press_elapsed_next = '0;
            end
            else if (!past_debounce)
            begin
                // Still inside the debounce time.
            end
            else if (!debounced_reg)
            begin
                if (in_window && !(&repeat_reg))
                begin
                    repeat_next = repeat_reg + COUNT_BITS'(1);
                end
                debounced_next = 1'b1;
            end
            else if (past_hold)
            begin
                if (!held_reg)
                begin
                    hold_pending_next = 1'b1;
                end
                held_next = 1'b1;
            end
        end
        else
        begin
            if (press_timing_reg && past_debounce)
            begin
                release_elapsed_next = '0;
                if (!held_reg && debounced_reg)
                begin
                    press_pending_next = 1'b1;
                end
                debounced_next    = 1'b0;
                held_next         = 1'b0;
                hold_pending_next = 1'b0;
            end
            else if (!in_window)
            begin
                repeat_next = '0;
            end
            press_timing_next  = 1'b0;
            press_elapsed_next = '0;
        end
    end

    assign repeat_wide = DSP_W'(repeat_next);

    always_comb
    begin
        result_next.press_event  = press_pending_next;
        result_next.hold_event   = hold_pending_next;
        result_next.pressed_now  = debounced_next;
        result_next.held_now     = held_next;
        result_next.repeat_count = (repeat_wide > DSP_MAX) ? REPEAT_W'(DSP_MAX)
                                                           : REPEAT_W'(repeat_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_timing_reg    <= 1'b0;
            press_elapsed_reg   <= '0;
            release_elapsed_reg <= '1;
            debounced_reg       <= 1'b0;
            held_reg            <= 1'b0;
            press_pending_reg   <= 1'b0;
            hold_pending_reg    <= 1'b0;
            repeat_reg          <= '0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                press_timing_reg    <= press_timing_next;
                press_elapsed_reg   <= press_elapsed_next;
                release_elapsed_reg <= release_elapsed_next;
                debounced_reg       <= debounced_next;
                held_reg            <= held_next;
                press_pending_reg   <= press_pending_next;
                hold_pending_reg    <= hold_pending_next;
                repeat_reg          <= repeat_next;
                result_valid_reg    <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: rtl/bdphr_checker.sv
// ----------------------------------------------------------------------------
// Button debouncer port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_debounce_press_hold_repeat_top_defines.svh"

module bdphr_checker
    import bdphr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input result_t            result
);

    // A hold can only be reported while the press is still taken as held.
    `BDPHR_ASSERT(a_hold_means_held, result_valid && result.hold_event |-> result.held_now, "hold event without held state")

    // Held implies the debounced press is still active.
    `BDPHR_ASSERT(a_held_means_pressed, result_valid && result.held_now |-> result.pressed_now, "held without pressed")

    // With an empty output register, input is never held off.
    `BDPHR_ASSERT_ALWAYS(a_no_idle_stall, !result_valid |-> !item_stall, "input stalled with empty output")

    // A stalled result is kept unchanged until it is taken.
    `BDPHR_ASSERT(a_result_holds, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

endmodule

bind button_debounce_press_hold_repeat_top bdphr_checker u_bdphr_checker (.*);

FILE: tb/button_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button event checker
// Watches the sample, result and APB channels of the button debouncer. For
// each accepted sample it predicts the flags and the repeat count. Each
// accepted result is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module button_event_checker
    import bdphr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  item_t              item,
    input  logic               result_valid,
    input  logic               result_stall,
    input  result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 fail_count,
    output int                 outstanding
);

    // Shadow copy of the configuration registers.
    logic                  active_cfg;
    logic [CFG_TIME_W-1:0] debounce_cfg;
    logic [CFG_TIME_W-1:0] hold_cfg;
    logic [CFG_TIME_W-1:0] multi_cfg;

    // Predicted button state.
    logic                  timing;
    logic [CFG_TIME_W-1:0] since_press;
    logic [CFG_TIME_W-1:0] since_release;
    logic                  is_pressed;
    logic                  is_held;
    logic                  press_flag;
    logic                  hold_flag;
    logic [REPEAT_W-1:0]   repeats;

    result_t               expected_events [$];
    int                    failures;

    function automatic logic [CFG_TIME_W-1:0] timer_advance(input logic [CFG_TIME_W-1:0] v);
        return (v == '1) ? v : v + CFG_TIME_W'(1);
    endfunction

    task automatic advance_button(input item_t smp, output result_t res);
        logic pressed;
        pressed = (smp.pin_level == active_cfg);
        // Take bits only clear what was pending before this sample.
        if (smp.take_press)
            press_flag = 1'b0;
        if (smp.take_hold)
            hold_flag = 1'b0;
        since_release = timer_advance(since_release);
        if (timing)
            since_press = timer_advance(since_press);
        if (pressed)
        begin
            if (!timing)
            begin
                timing      = 1'b1;
                since_press = '0;
            end
            else if (since_press >= debounce_cfg)
            begin
                // The accept tick never raises hold as well.
                if (!is_pressed)
                begin
                    if (since_release < multi_cfg && repeats != '1)
                        repeats = repeats + REPEAT_W'(1);
                    is_pressed = 1'b1;
                end
                else if (since_press >= hold_cfg)
                begin
                    if (!is_held)
                        hold_flag = 1'b1;
                    is_held = 1'b1;
                end
            end
        end
        else
        begin
            if (timing && since_press >= debounce_cfg)
            begin
                since_release = '0;
                if (!is_held && is_pressed)
                    press_flag = 1'b1;
                is_pressed = 1'b0;
                is_held    = 1'b0;
                hold_flag  = 1'b0;
            end
            else if (repeats != '0 && since_release >= multi_cfg)
            begin
                repeats = '0;
            end
            timing      = 1'b0;
            since_press = '0;
        end
        res.press_event  = press_flag;
        res.hold_event   = hold_flag;
        res.pressed_now  = is_pressed;
        res.held_now     = is_held;
        res.repeat_count = repeats;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t next_result;
        if (!rst_n)
        begin
            active_cfg    = RST_ACTIVE_LEVEL;
            debounce_cfg  = RST_DEBOUNCE;
            hold_cfg      = RST_HOLD;
            multi_cfg     = RST_MULTI_PRESS;
            timing        = 1'b0;
            since_press   = '0;
            since_release = '1;
            is_pressed    = 1'b0;
            is_held       = 1'b0;
            press_flag    = 1'b0;
            hold_flag     = 1'b0;
            repeats       = '0;
            expected_events.delete();
            failures      = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // The result leaving now belongs to an earlier sample, so it is
            // checked before this cycle's sample is predicted.
            if (result_valid && !result_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    failures++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("press_event", want.press_event, result.press_event);
                    check_field("hold_event", want.hold_event, result.hold_event);
                    check_field("pressed_now", want.pressed_now, result.pressed_now);
                    check_field("held_now", want.held_now, result.held_now);
                    check_field("repeat_count", want.repeat_count, result.repeat_count);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_ACTIVE_LEVEL: active_cfg   = pwdata[0];
                    REG_DEBOUNCE:     debounce_cfg = pwdata[CFG_TIME_W-1:0];
                    REG_HOLD:         hold_cfg     = pwdata[CFG_TIME_W-1:0];
                    REG_MULTI_PRESS:  multi_cfg    = pwdata[CFG_TIME_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                advance_button(item, next_result);
                expected_events.push_back(next_result);
            end
            fail_count  <= failures;
            outstanding <= expected_events.size();
        end
    end

endmodule

FILE: tb/tb_button_debounce_press_hold_repeat_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debouncer testbench
// Drives pin samples with random take bits through several register settings
// and random idling on both channels; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_button_debounce_press_hold_repeat_top;
    import bdphr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    item_t              item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_t            result;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    int                 fail_count;
    int                 outstanding;
    int                 cycles        = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    logic               cur_level     = RST_ACTIVE_LEVEL;

    // Hand-made press sequence, {pin_level, take_press, take_hold}, run with
    // active level high, debounce 2, hold 4 and repeat window 6.
    logic [2:0] directed_seq [0:23] = '{
        // a press too short to pass debounce is dropped
        3'b100, 3'b100, 3'b000,
        // long press; hold is raised on a tick that also takes hold
        3'b100, 3'b100, 3'b100, 3'b100, 3'b101, 3'b101,
        3'b000,
        // short press gives a press event and another repeat
        3'b100, 3'b100, 3'b100, 3'b000,
        // another repeat; release raises an event on a take tick
        3'b110, 3'b100, 3'b100, 3'b010,
        // wait out the repeat window so the count clears
        3'b011, 3'b000, 3'b000, 3'b000, 3'b000, 3'b000
    };

    button_debounce_press_hold_repeat_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    button_event_checker event_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic level, input logic [CFG_TIME_W-1:0] debounce,
                              input logic [CFG_TIME_W-1:0] hold,
                              input logic [CFG_TIME_W-1:0] multi);
        apb_write(REG_ACTIVE_LEVEL, {31'b0, level});
        apb_write(REG_DEBOUNCE, {8'b0, debounce});
        apb_write(REG_HOLD, {8'b0, hold});
        apb_write(REG_MULTI_PRESS, {8'b0, multi});
        cur_level = level;
    endtask

    // Stops sending and waits until every predicted result has been read.
    task automatic wait_quiet();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic send_sample(input logic pressed);
        item_t it;
        it.pin_level  = pressed ? cur_level : ~cur_level;
        it.take_press = ($urandom_range(3) == 0);
        it.take_hold  = ($urandom_range(3) == 0);
        send_item(it);
    endtask

    // Mostly clean press and release runs with a rare bounce; the rest is
    // random pin noise.
    task automatic run_presses(input int count, input int min_on, input int max_on,
                               input int max_off);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(min_on, max_on);
                repeat (len) send_sample($urandom_range(49) != 0);
                sent += len;
                len = $urandom_range(1, max_off);
                repeat (len) send_sample($urandom_range(49) == 0);
                sent += len;
            end
            else
            begin
                len = $urandom_range(1, 8);
                repeat (len) send_sample(1'($urandom_range(1)));
                sent += len;
            end
        end
    endtask

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 62;
        // Registers still hold their reset values here.
        run_presses(120, 55, 80, 10);
        wait_quiet();

        set_config(1'b1, 24'd2, 24'd4, 24'd6);
        foreach (directed_seq[k])
            send_item(directed_seq[k]);
        wait_quiet();

        set_config(1'b0, 24'd3, 24'd12, 24'd10);
        run_presses(400, 1, 20, 16);
        wait_quiet();

        // Hold never comes and every press is a repeat, so the count saturates.
        send_idle_pct = 62;
        recv_idle_pct = 29;
        set_config(1'b1, 24'd0, '1, '1);
        run_presses(1100, 2, 2, 1);
        wait_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(1'b0, '1, 24'd0, 24'd0);
        run_presses(80, 1, 10, 5);
        wait_quiet();

        set_config(1'b1, 24'd0, 24'd0, 24'd0);
        run_presses(200, 1, 6, 4);
        wait_quiet();

        set_config(1'b0, RST_DEBOUNCE, 24'd120, RST_MULTI_PRESS);
        run_presses(200, 20, 150, 350);
        wait_quiet();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/bdphr_pkg.sv
rtl/button_debounce_press_hold_repeat_top.sv
rtl/bdphr_checker.sv
tb/button_event_checker.sv
tb/tb_button_debounce_press_hold_repeat_top.sv
